/* src/gdac_pkg.sv */
// ---------------------------------------------------------------------------
// Gas detector alarm controller package
// Item types, mode and lamp codes, limits and register indexes shared by the
// controller modules.
// ---------------------------------------------------------------------------
package gdac_pkg;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SUM_W    = 16;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [3:0] PAIRS_PER_ROUND = 4'd12;

   localparam logic [SAMPLE_W-1:0] SUPPLY_LOW    = 12'd200;
   localparam logic [SAMPLE_W-1:0] SUPPLY_HIGH   = 12'd300;
   localparam logic [SAMPLE_W-1:0] SUPPLY_FAULT  = 12'd500;
   localparam logic [SAMPLE_W-1:0] METHANE_OPEN  = 12'd20;
   localparam logic [SAMPLE_W-1:0] METHANE_SHORT = 12'd4050;
   localparam logic [SAMPLE_W-1:0] MIN_DELTA     = 12'd10;

   localparam logic [COUNT_W-1:0]  PREHEAT_DEFAULT   = 8'd180;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_DEFAULT = 12'd2048;

   localparam logic [MODE_W-1:0] MODE_SELFTEST = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PREHEAT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALARM    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd4;

   localparam logic [1:0] GREEN_OFF    = 2'd0;
   localparam logic [1:0] GREEN_ON     = 2'd1;
   localparam logic [1:0] GREEN_TOGGLE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREHEAT_ROUNDS  = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] methane_sample;
      logic [SAMPLE_W-1:0] supply_sample;
      logic                key_pressed;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_methane;
      logic [SAMPLE_W-1:0] avg_supply;
      logic [MODE_W-1:0]   mode;
      logic [COUNT_W-1:0]  preheat_left;
      logic [1:0]          green_lamp;
      logic                red_lamp;
      logic                yellow_lamp;
      logic                buzzer;
      logic                relay_on;
      logic                valve_pulse;
      logic                self_test;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_methane;
      logic [SAMPLE_W-1:0] avg_supply;
      logic                key_pressed;
   } avg_type;

endpackage

/* src/gdac_avg.sv */
// ---------------------------------------------------------------------------
// Round averager
// Adds up twelve sample pairs, registers the round sums and divides each sum
// by twelve into a registered round item for the mode controller.
// ---------------------------------------------------------------------------
module gdac_avg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gdac_pkg::req_type req_item,
   output logic              avg_valid,
   input  logic              avg_ready,
   output gdac_pkg::avg_type avg_item
);
   import gdac_pkg::*;

   localparam logic [16:0] RECIP_THREE = 17'd43691;

   logic [SUM_W-1:0] msum_ff, msum_in;
   logic [SUM_W-1:0] ssum_ff, ssum_in;
   logic [3:0]       pair_count_ff, pair_count_in;
   logic [SUM_W-1:0] rnd_msum_ff, rnd_ssum_ff;
   logic             rnd_key_ff;
   logic             rnd_valid_ff, rnd_valid_in;
   logic             avg_valid_ff, avg_valid_in;
   avg_type          avg_ff;
   logic             accept, last_pair, rnd_move;
   logic [SUM_W-1:0] msum_add, ssum_add;
   logic [30:0]      mprod, sprod;

   assign rnd_move  = ~avg_valid_ff | avg_ready;
   assign req_ready = ~rnd_valid_ff | rnd_move;
   assign accept    = req_valid & req_ready;
   assign last_pair = (pair_count_ff == PAIRS_PER_ROUND - 4'd1);

   assign msum_add = msum_ff + SUM_W'(req_item.methane_sample);
   assign ssum_add = ssum_ff + SUM_W'(req_item.supply_sample);

   // A sum divided by twelve is the sum divided by four, then by three
   // through a reciprocal multiply.
   assign mprod = {17'd0, rnd_msum_ff[SUM_W-1:2]} * {14'd0, RECIP_THREE};
   assign sprod = {17'd0, rnd_ssum_ff[SUM_W-1:2]} * {14'd0, RECIP_THREE};

   always_comb begin
      msum_in       = msum_ff;
      ssum_in       = ssum_ff;
      pair_count_in = pair_count_ff;
      rnd_valid_in  = rnd_valid_ff;
      if (rnd_move) begin
         rnd_valid_in = 1'b0;
      end
      if (accept) begin
         if (last_pair) begin
            msum_in       = '0;
            ssum_in       = '0;
            pair_count_in = '0;
            rnd_valid_in  = 1'b1;
         end else begin
            msum_in       = msum_add;
            ssum_in       = ssum_add;
            pair_count_in = pair_count_ff + 4'd1;
         end
      end
      avg_valid_in = rnd_move ? rnd_valid_ff : avg_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msum_ff       <= '0;
         ssum_ff       <= '0;
         pair_count_ff <= '0;
         rnd_valid_ff  <= 1'b0;
         avg_valid_ff  <= 1'b0;
      end else begin
         msum_ff       <= msum_in;
         ssum_ff       <= ssum_in;
         pair_count_ff <= pair_count_in;
         rnd_valid_ff  <= rnd_valid_in;
         avg_valid_ff  <= avg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_pair) begin
         rnd_msum_ff <= msum_add;
         rnd_ssum_ff <= ssum_add;
         rnd_key_ff  <= req_item.key_pressed;
      end
      if (rnd_move) begin
         avg_ff.avg_methane <= mprod[28:17];
         avg_ff.avg_supply  <= sprod[28:17];
         avg_ff.key_pressed <= rnd_key_ff;
      end
   end

   assign avg_valid = avg_valid_ff;
   assign avg_item  = avg_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff < PAIRS_PER_ROUND)
      else $error("pair count left its range");
   a_round_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_pair |=> msum_ff == '0 && ssum_ff == '0 && rnd_valid_ff)
      else $error("round end did not clear the sums");

endmodule

/* src/gdac_ctl.sv */
// ---------------------------------------------------------------------------
// Mode controller
// Holds the configuration registers and the mode state, updates the mode from
// each round's averages and registers the result item with its commands.
// ---------------------------------------------------------------------------
module gdac_ctl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [gdac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gdac_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 avg_valid,
   output logic                                 avg_ready,
   input  gdac_pkg::avg_type                    avg_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gdac_pkg::rsp_type                    rsp_item
);
   import gdac_pkg::*;

   logic [SAMPLE_W-1:0] threshold_ff;
   logic [COUNT_W-1:0]  preheat_rounds_ff;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [COUNT_W-1:0]  preheat_ff, preheat_in;
   logic                valve_done_ff, valve_done_in;
   logic                silenced_ff, silenced_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                accept;
   logic [MODE_W-1:0]   upd_mode;
   logic [SAMPLE_W-1:0] ch4, sup, delta;
   logic                supply_ok;

   assign avg_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = avg_valid & avg_ready;

   assign ch4       = avg_item.avg_methane;
   assign sup       = avg_item.avg_supply;
   assign delta     = (ch4 > sup) ? (ch4 - sup) : (sup - ch4);
   assign supply_ok = (sup >= SUPPLY_LOW) && (sup < SUPPLY_HIGH);

   always_comb begin
      case (mode_ff)
         MODE_SELFTEST, MODE_PREHEAT: begin
            upd_mode = mode_ff;
         end
         MODE_NORMAL: begin
            upd_mode = mode_ff;
            if (supply_ok && ch4 > threshold_ff) begin
               upd_mode = MODE_ALARM;
            end
            if (sup > SUPPLY_FAULT || ch4 < METHANE_OPEN || ch4 > METHANE_SHORT
                || delta < MIN_DELTA) begin
               upd_mode = MODE_FAULT;
            end
         end
         MODE_ALARM: begin
            upd_mode = (ch4 < threshold_ff) ? MODE_NORMAL : MODE_ALARM;
         end
         MODE_FAULT: begin
            upd_mode = MODE_FAULT;
            if (supply_ok && ch4 < threshold_ff) begin
               upd_mode = MODE_NORMAL;
            end else if (supply_ok && ch4 < METHANE_SHORT) begin
               upd_mode = MODE_ALARM;
            end
         end
         default: begin
            upd_mode = MODE_NORMAL;
         end
      endcase
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.avg_methane = ch4;
      rsp_in.avg_supply  = sup;
      rsp_in.green_lamp  = GREEN_OFF;
      mode_in            = upd_mode;
      preheat_in         = preheat_ff;
      valve_done_in      = valve_done_ff;
      silenced_in        = silenced_ff;
      case (upd_mode)
         MODE_SELFTEST: begin
            rsp_in.self_test = 1'b1;
            preheat_in       = preheat_rounds_ff;
            mode_in          = MODE_PREHEAT;
         end
         MODE_PREHEAT: begin
            if (preheat_ff != '0) begin
               preheat_in = preheat_ff - 8'd1;
            end
            if (avg_item.key_pressed) begin
               preheat_in = '0;
            end
            if (preheat_in == '0) begin
               mode_in = MODE_NORMAL;
            end
            rsp_in.green_lamp = GREEN_TOGGLE;
         end
         MODE_NORMAL: begin
            valve_done_in     = 1'b0;
            silenced_in       = 1'b0;
            rsp_in.green_lamp = GREEN_ON;
            rsp_in.self_test  = avg_item.key_pressed;
         end
         MODE_ALARM: begin
            rsp_in.green_lamp  = GREEN_ON;
            rsp_in.red_lamp    = 1'b1;
            rsp_in.relay_on    = 1'b1;
            silenced_in        = silenced_ff | avg_item.key_pressed;
            rsp_in.valve_pulse = ~valve_done_ff;
            valve_done_in      = 1'b1;
            rsp_in.buzzer      = ~silenced_in;
         end
         default: begin
            silenced_in        = 1'b0;
            rsp_in.yellow_lamp = 1'b1;
            rsp_in.buzzer      = 1'b1;
         end
      endcase
      rsp_in.mode         = mode_in;
      rsp_in.preheat_left = preheat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff      <= THRESHOLD_DEFAULT;
         preheat_rounds_ff <= PREHEAT_DEFAULT;
         mode_ff           <= MODE_SELFTEST;
         preheat_ff        <= PREHEAT_DEFAULT;
         valve_done_ff     <= 1'b0;
         silenced_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_ALARM_THRESHOLD) begin
            threshold_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_PREHEAT_ROUNDS) begin
            preheat_rounds_ff <= csr_wdata[COUNT_W-1:0];
         end
         if (accept) begin
            mode_ff       <= mode_in;
            preheat_ff    <= preheat_in;
            valve_done_ff <= valve_done_in;
            silenced_ff   <= silenced_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SELFTEST || mode_ff == MODE_PREHEAT || mode_ff == MODE_NORMAL
      || mode_ff == MODE_ALARM || mode_ff == MODE_FAULT)
      else $error("mode register holds an unused code");
   a_valve_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.valve_pulse |-> rsp_ff.mode == MODE_ALARM && valve_done_ff)
      else $error("valve pulse outside an alarm round");
   a_relay_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.relay_on == (rsp_ff.mode == MODE_ALARM))
      else $error("relay drive does not follow the alarm mode");
   a_mode_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.mode == mode_ff && rsp_ff.preheat_left == preheat_ff)
      else $error("result mode differs from the held mode");

endmodule

/* src/gas_detector_alarm_controller.sv */
// ---------------------------------------------------------------------------
// Gas detector alarm controller
// Averages twelve methane and supply sample pairs per round and runs the
// self-test, preheat, normal, alarm and fault modes from the averages.
// ---------------------------------------------------------------------------
// The edge that accepts the twelfth item of a round registers the round
// sums; the divided round item and then the mode-updated result follow.
// Throughput: one item per cycle unless stalled; one result per twelve items.
// Reset clears the sums and pair count, sets the mode to self-test, the
// countdown to 180 and the registers to threshold 2048 and 180 rounds.
// ---------------------------------------------------------------------------
module gas_detector_alarm_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gdac_pkg::req_type               req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gdac_pkg::rsp_type               rsp_item,
   input  logic                            csr_we,
   input  logic [gdac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gdac_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gdac_pkg::*;

   logic    avg_valid, avg_ready;
   avg_type avg_item;

   gdac_avg u_avg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg_item  (avg_item)
   );

   gdac_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg_item  (avg_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
